// File: design/spot_weld_phase_timer_core_assert.svh
// Assertion macros for the spot weld phase timer core.
// Included by the top level; no other dependencies.
`ifndef SPOT_WELD_PHASE_TIMER_CORE_ASSERT_SVH
`define SPOT_WELD_PHASE_TIMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset
`define SWPT_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swpt same-cycle check failed");
// Next-cycle implication
`define SWPT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swpt next-cycle check failed");
`else
`define SWPT_ASSERT_SAME(lbl, clk, rst, pre, post)
`define SWPT_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: design/swpt_pkg.sv
// Package for the spot weld phase timer: payload structs, codes, weld table.
// No dependencies; used by spot_weld_phase_timer_core.
`timescale 1ns / 1ps

package swpt_pkg;

  // Event codes
  localparam logic OP_GATE_ON  = 1'b0;
  localparam logic OP_HALF_END = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MACHINE_VARIANT = 2'd0;
  localparam logic [1:0] CFG_WELD_MODE       = 2'd1;
  localparam logic [1:0] CFG_POWER_LEVEL     = 2'd2;

  // Welder variants
  localparam logic [1:0] VAR_LARGE  = 2'd0;
  localparam logic [1:0] VAR_MEDIUM = 2'd1;
  localparam logic [1:0] VAR_SMALL  = 2'd2;
  localparam logic [1:0] VAR_LINEAR = 2'd3;

  // Weld lengths in half cycles
  localparam logic [15:0] LEN_LARGE_M0 = 16'd600;
  localparam logic [15:0] LEN_LARGE_M1 = 16'd360;
  localparam logic [15:0] LEN_LARGE_M2 = 16'd85;
  localparam logic [15:0] LEN_LARGE_M3 = 16'd18;
  localparam logic [15:0] LEN_LONG     = 16'd1800;
  localparam logic [15:0] LEN_SHORT    = 16'd20;
  localparam logic [4:0]  LEN_LIN_BASE = 5'd6;

  // Firing delay bases
  localparam logic [7:0] DELAY_SLOW_BASE = 8'd128;
  localparam logic [7:0] DELAY_FAST_BASE = 8'd150;

  // Cooldown
  localparam logic [15:0] WAIT_HALF_CYCLES = 16'd50;
  localparam logic [15:0] COOL_MAX         = 16'hFFFF;

  typedef struct packed {
    logic operation;
    logic trigger_held;
    logic weld_enable;
  } item_t;

  typedef struct packed {
    logic       gate_drive;
    logic [7:0] firing_delay;
    logic       welding;
    logic       mains_phase;
  } result_t;

  typedef struct packed {
    logic        trig;
    logic        high;
    logic        manu;
    logic        pulse;
  } flags_t;

  typedef struct packed {
    logic [15:0] len;
    logic        manual;
    logic [7:0]  delay;
  } table_t;

  // Weld table: length, manual flag and firing delay (delays wrap mod 256)
  function automatic table_t weld_table(input logic [1:0] variant,
                                        input logic [1:0] mode,
                                        input logic [3:0] power);
    logic [7:0] slow;
    logic [7:0] fast;
    logic [4:0] lin;
    table_t     t;
    slow = DELAY_SLOW_BASE - ({2'b00, power, 2'b00} + {4'b0000, power});
    fast = DELAY_FAST_BASE - {1'b0, power, 3'b000};
    lin  = LEN_LIN_BASE + {1'b0, mode, 2'b00} + {3'b000, mode};
    t.delay = fast;
    case (variant)
      VAR_LARGE: begin
        case (mode)
          2'd0: begin
            t.len = LEN_LARGE_M0; t.manual = 1'b1; t.delay = slow;
          end
          2'd1: begin
            t.len = LEN_LARGE_M1; t.manual = 1'b1; t.delay = slow;
          end
          2'd2: begin
            t.len = LEN_LARGE_M2; t.manual = 1'b0;
          end
          default: begin
            t.len = LEN_LARGE_M3; t.manual = 1'b0;
          end
        endcase
      end
      VAR_MEDIUM: begin
        t.len    = mode[1] ? LEN_SHORT : LEN_LONG;
        t.manual = ~mode[1];
      end
      VAR_SMALL: begin
        t.len    = mode[1] ? LEN_LONG : LEN_SHORT;
        t.manual = mode[1];
      end
      default: begin
        t.len    = {11'd0, lin};
        t.manual = 1'b0;
      end
    endcase
    return t;
  endfunction

endpackage

// File: design/spot_weld_phase_timer_core.sv
// Spot weld phase timer: one result per event, registered output.
// Latency: the result is valid the cycle after the event transfer.
// Throughput: one event per cycle; the only stall is a stalled full result register.
// Reset: synchronous active-high rst clears all weld state, config and result valid.
// Depends on swpt_pkg and spot_weld_phase_timer_core_assert.svh.
`timescale 1ns / 1ps
`include "spot_weld_phase_timer_core_assert.svh"

module spot_weld_phase_timer_core #(
  parameter logic [15:0] WAIT_HALF_CYCLES = swpt_pkg::WAIT_HALF_CYCLES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  swpt_pkg::item_t item,
  output logic            result_valid,
  input  logic            result_stall,
  output swpt_pkg::result_t result,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [3:0]      cfg_data
);

  // Configuration registers
  logic [1:0] machine_variant;
  logic [1:0] weld_mode;
  logic [3:0] power_level;

  // Weld state
  swpt_pkg::flags_t flags, flags_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] cooldown, cooldown_next;
  logic [15:0] weld_length, weld_length_next;
  logic        manual_mode, manual_mode_next;
  logic        last_start_phase, last_start_phase_next;
  logic        phase_bit, phase_bit_next;
  logic        gate_level, gate_level_next;
  logic [7:0]  delay_reg, delay_reg_next;

  logic             item_take;
  swpt_pkg::table_t tbl_cur;
  swpt_pkg::table_t tbl_start;
  logic [15:0]      elapsed;
  logic             start_ok;

  // Saturating cooldown add
  function automatic logic [15:0] cool_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? swpt_pkg::COOL_MAX : s[15:0];
  endfunction

  // Output register can take a new result when empty or being drained
  assign item_stall = result_valid & result_stall;
  assign item_take  = item_valid & ~item_stall;

  assign tbl_cur   = swpt_pkg::weld_table(machine_variant, weld_mode, power_level);
  assign tbl_start = swpt_pkg::weld_table(machine_variant, weld_mode, 4'd0);
  assign elapsed   = weld_length - remaining;

  // Event processing
  always_comb begin
    flags_next            = flags;
    remaining_next        = remaining;
    cooldown_next         = cooldown;
    weld_length_next      = weld_length;
    manual_mode_next      = manual_mode;
    last_start_phase_next = last_start_phase;
    phase_bit_next        = phase_bit;
    gate_level_next       = gate_level;
    delay_reg_next        = delay_reg;
    start_ok              = 1'b0;
    if (item.operation == swpt_pkg::OP_GATE_ON) begin
      // reload table at the selected power; fire if a weld runs and weld_enable is set
      weld_length_next = tbl_cur.len;
      manual_mode_next = tbl_cur.manual;
      delay_reg_next   = tbl_cur.delay;
      if (flags.high && item.weld_enable) begin
        gate_level_next = 1'b1;
      end
    end else begin
      if (flags.pulse || !flags.high) begin
        gate_level_next = 1'b0;
      end
      // weld progress and end
      if (flags.high) begin
        if (flags.manu && !flags.trig) begin
          if (weld_length > remaining) begin
            cooldown_next = cool_add(cooldown_next, elapsed);
          end
          remaining_next = 16'd0;
        end
        if (remaining_next == 16'd0) begin
          flags_next.high       = 1'b0;
          flags_next.manu       = 1'b0;
          flags_next.pulse      = 1'b0;
          cooldown_next         = cool_add(cooldown_next, WAIT_HALF_CYCLES);
          last_start_phase_next = phase_bit;
        end else begin
          remaining_next = remaining_next - 16'd1;
        end
      end
      // weld start: first half cycle at power zero
      if (item.trigger_held) begin
        start_ok = !flags_next.trig && !flags_next.high && (cooldown_next == 16'd0) &&
                   (last_start_phase_next != phase_bit) && item.weld_enable;
        if (start_ok) begin
          flags_next.trig  = 1'b1;
          flags_next.high  = 1'b1;
          flags_next.manu  = tbl_start.manual;
          flags_next.pulse = 1'b1;
          remaining_next   = weld_length;
          weld_length_next = tbl_start.len;
          manual_mode_next = tbl_start.manual;
          delay_reg_next   = tbl_start.delay;
        end
      end else begin
        flags_next.trig = 1'b0;
      end
      if (cooldown_next != 16'd0) begin
        cooldown_next = cooldown_next - 16'd1;
      end
      phase_bit_next = ~phase_bit;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      machine_variant <= 2'd0;
      weld_mode       <= 2'd0;
      power_level     <= 4'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        swpt_pkg::CFG_MACHINE_VARIANT: machine_variant <= cfg_data[1:0];
        swpt_pkg::CFG_WELD_MODE:       weld_mode       <= cfg_data[1:0];
        swpt_pkg::CFG_POWER_LEVEL:     power_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // State update on each event transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      flags            <= '0;
      remaining        <= 16'd0;
      cooldown         <= 16'd0;
      weld_length      <= 16'd0;
      manual_mode      <= 1'b0;
      last_start_phase <= 1'b0;
      phase_bit        <= 1'b0;
      gate_level       <= 1'b0;
      delay_reg        <= 8'd0;
    end else if (item_take) begin
      flags            <= flags_next;
      remaining        <= remaining_next;
      cooldown         <= cooldown_next;
      weld_length      <= weld_length_next;
      manual_mode      <= manual_mode_next;
      last_start_phase <= last_start_phase_next;
      phase_bit        <= phase_bit_next;
      gate_level       <= gate_level_next;
      delay_reg        <= delay_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      result.gate_drive   <= gate_level_next;
      result.firing_delay <= delay_reg_next;
      result.welding      <= flags_next.high;
      result.mains_phase  <= phase_bit_next;
    end
  end

  // Checks
  `SWPT_ASSERT_SAME(a_gate_only_in_weld, clk, rst, gate_level, flags.high)
  `SWPT_ASSERT_SAME(a_manual_only_in_weld, clk, rst, flags.manu, flags.high)
  `SWPT_ASSERT_NEXT(a_take_fills_result, clk, rst, item_take, result_valid)
  `SWPT_ASSERT_NEXT(a_half_end_flips_phase, clk, rst,
    item_take && (item.operation == swpt_pkg::OP_HALF_END), phase_bit != $past(phase_bit))

endmodule

// File: tb/sv/spot_weld_phase_timer_core_test.sv
// Self-checking testbench for spot_weld_phase_timer_core: directed and random mains
// event streams, with a weld-timer predictor and an in-order scoreboard.
// Depends on swpt_pkg and the spot_weld_phase_timer_core RTL.
`timescale 1ns / 1ps

module spot_weld_phase_timer_core_test;
  import swpt_pkg::*;

  localparam int END_WAIT_HALF_CYCLES = 50;
  localparam int COOLDOWN_CEILING     = 65535;
  localparam int LONG_HOLD_CYCLES     = 120;
  localparam int PHASES               = 16;

  // Weld timer predictor plus the queue of results it expects
  class weld_event_scoreboard;
    logic [1:0]  variant;
    logic [1:0]  mode;
    logic [3:0]  power;
    flags_t      flags;
    logic [15:0] remaining;
    logic [15:0] cooldown;
    logic [15:0] length;
    logic        manual;
    logic        last_phase;
    logic        phase;
    logic        gate;
    logic [7:0]  delay;
    result_t     expected_results[$];
    int          errors;

    function new();
      variant = '0; mode = '0; power = '0;
      flags = '0; remaining = '0; cooldown = '0; length = '0;
      manual = 1'b0; last_phase = 1'b0; phase = 1'b0; gate = 1'b0; delay = '0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [3:0] data);
      case (index)
        CFG_MACHINE_VARIANT: variant = data[1:0];
        CFG_WELD_MODE:       mode = data[1:0];
        CFG_POWER_LEVEL:     power = data;
        default: ;
      endcase
    endfunction

    // Weld length, manual flag and firing delay for the current variant
    function void reload_table(logic [1:0] m, logic [3:0] p);
      int         pw;
      logic [7:0] slow;
      logic [7:0] fast;
      pw = p;
      slow = 8'(128 - 5 * pw);
      fast = 8'(150 - 8 * pw);
      delay = fast;
      case (variant)
        VAR_LARGE: begin
          manual = (m < 2'd2);
          case (m)
            2'd0: length = 16'd600;
            2'd1: length = 16'd360;
            2'd2: length = 16'd85;
            default: length = 16'd18;
          endcase
          if (m < 2'd2) delay = slow;
        end
        VAR_MEDIUM: begin
          length = m[1] ? 16'd20 : 16'd1800;
          manual = ~m[1];
        end
        VAR_SMALL: begin
          length = m[1] ? 16'd1800 : 16'd20;
          manual = m[1];
        end
        default: begin
          length = 16'(6 + 5 * int'(m));
          manual = 1'b0;
        end
      endcase
    endfunction

    function void add_cooldown(int unsigned amount);
      int unsigned sum;
      sum = cooldown + amount;
      cooldown = (sum > COOLDOWN_CEILING) ? 16'hFFFF : sum[15:0];
    endfunction

    // Weld bookkeeping at the end of a mains half cycle
    function void finish_half_cycle(logic trig, logic en);
      if (flags.high) begin
        // manual weld released: charge the elapsed time, then end it
        if (flags.manu && !flags.trig) begin
          if (length > remaining) add_cooldown(length - remaining);
          remaining = '0;
        end
        if (remaining == 0) begin
          flags.high = 1'b0;
          flags.manu = 1'b0;
          flags.pulse = 1'b0;
          add_cooldown(END_WAIT_HALF_CYCLES);
          last_phase = phase;
        end else begin
          remaining = remaining - 16'd1;
        end
      end else begin
        gate = 1'b0;
      end

      if (trig) begin
        if (!flags.trig && !flags.high && cooldown == 0 && last_phase != phase && en) begin
          flags = '0;
          flags.trig = 1'b1;
          flags.high = 1'b1;
          remaining = length;
          // first half cycle fires at power zero
          reload_table(mode, 4'd0);
          flags.manu = manual;
          flags.pulse = 1'b1;
        end
      end else begin
        flags.trig = 1'b0;
      end

      if (cooldown > 0) cooldown = cooldown - 16'd1;
    endfunction

    function void note_event(item_t it);
      result_t r;
      if (it.operation == OP_GATE_ON) begin
        reload_table(mode, power);
        if (flags.high && it.weld_enable) gate = 1'b1;
      end else begin
        if (flags.pulse || !flags.high) gate = 1'b0;
        finish_half_cycle(it.trigger_held, it.weld_enable);
        phase = ~phase;
      end
      r.gate_drive = gate;
      r.firing_delay = delay;
      r.welding = flags.high;
      r.mains_phase = phase;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, logic [7:0] got);
      if (^got === 1'bx || got != want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("gate_drive", want.gate_drive, {7'd0, got.gate_drive});
      compare_field("firing_delay", want.firing_delay, got.firing_delay);
      compare_field("welding", want.welding, {7'd0, got.welding});
      compare_field("mains_phase", want.mains_phase, {7'd0, got.mains_phase});
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_MACHINE_VARIANT;
  logic [3:0] cfg_data = '0;

  weld_event_scoreboard book = new();

  bit no_idle = 1'b0;
  bit offering = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;

  // Opening events: {operation, trigger_held, weld_enable}
  logic [2:0] opening_seq [16] = '{
    3'b111, 3'b001, 3'b111, 3'b001, 3'b010, 3'b111, 3'b001, 3'b101,
    3'b000, 3'b101, 3'b111, 3'b011, 3'b110, 3'b100, 3'b000, 3'b011
  };

  // Settings for the first phases, extremes included
  logic [1:0] variant_plan [8] = '{VAR_LINEAR, VAR_LINEAR, VAR_LARGE, VAR_MEDIUM,
                                   VAR_SMALL, VAR_MEDIUM, VAR_SMALL, VAR_LARGE};
  logic [1:0] mode_plan [8] = '{2'd0, 2'd3, 2'd2, 2'd0, 2'd3, 2'd3, 2'd0, 2'd1};
  logic [3:0] power_plan [8] = '{4'd15, 4'd0, 4'd15, 4'd7, 4'd0, 4'd15, 4'd5, 4'd0};

  spot_weld_phase_timer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one event and hold it until the transfer
  task automatic send_item(item_t it);
    int gap;
    item <= it;
    item_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (item_stall);
    book.note_event(it);
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and let every expected result come back
  task automatic wait_drained();
    if (offering) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
    while (book.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; the block is idle here
  task automatic apply_settings(logic [1:0] v, logic [1:0] m, logic [3:0] p);
    logic [3:0] data [3];
    int i;
    data[0] = {2'($urandom_range(0, 3)), v};
    data[1] = {2'($urandom_range(0, 3)), m};
    data[2] = p;
    cfg_write <= 1'b1;
    for (i = 0; i < 3; i++) begin
      cfg_index <= 2'(i);
      cfg_data <= data[i];
      @(posedge clk);
      book.set_register(2'(i), data[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) book.check_result(result);
  end

  // Receiver back-pressure, with an occasional long hold-off on request
  initial begin : stall_driver
    int n;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        result_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         phase;
    int         k;
    int         count;
    int         trig_left;
    logic       trig_level;
    logic       next_op;
    item_t      it;
    logic [1:0] v;
    logic [1:0] m;
    logic [3:0] p;

    trig_left = 0;
    trig_level = 1'b0;
    next_op = OP_GATE_ON;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under reset settings: manual weld start, early release,
    // gate with enable low, blocked restart during cooldown
    for (k = 0; k < 16; k++) send_item(item_t'(opening_seq[k]));
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 8) begin
        v = variant_plan[phase];
        m = mode_plan[phase];
        p = power_plan[phase];
      end else begin
        v = 2'($urandom_range(0, 3));
        m = 2'($urandom_range(0, 3));
        p = 4'($urandom_range(0, 15));
      end
      apply_settings(v, m, p);
      no_idle = (phase == 3 || phase == 9);
      if (phase == 2 || phase == 11) hold_requests++;
      count = $urandom_range(80, 110);

      for (k = 0; k < count; k++) begin
        if (phase == 6 && k == count / 2) wait_drained();
        // mostly alternating gate-on / half-cycle end, with some noise
        if ($urandom_range(0, 19) == 0) it.operation = 1'($urandom_range(0, 1));
        else it.operation = next_op;
        next_op = (it.operation == OP_GATE_ON) ? OP_HALF_END : OP_GATE_ON;
        if (it.operation == OP_HALF_END) begin
          // trigger presses and releases of random length
          if (trig_left == 0) begin
            trig_level = ~trig_level;
            if (trig_level)
              trig_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 30);
            else
              trig_left = $urandom_range(1, 8);
          end
          trig_left--;
          it.trigger_held = ($urandom_range(0, 29) == 0) ? ~trig_level : trig_level;
        end else begin
          it.trigger_held = 1'($urandom_range(0, 1));
        end
        it.weld_enable = ($urandom_range(0, 9) != 0);
        send_item(it);
      end
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
